>>> rtl/lphs_pkg.sv
// Shared types and constants, including the key-hash multipliers, for the hash set.
`default_nettype none
package lphs_pkg;
  localparam int unsigned TableEntriesDef = 1024;
  localparam int unsigned QueueDepth = 2;
  localparam logic [31:0] MixMulA = 32'h85ebca6b;
  localparam logic [31:0] MixMulB = 32'hc2b2ae35;

  // Command codes.
  localparam logic CmdLookup = 1'b0;
  localparam logic CmdInsert = 1'b1;

  // One item after the front part has hashed it.
  typedef struct packed {
    logic        cmd;
    logic [31:0] key;
    logic [31:0] hash;
  } lphs_job_t;
endpackage
`default_nettype wire

>>> rtl/lphs_front.sv
// Front part: accepts items and hashes the key over two multiply stages.
`default_nettype none
module lphs_front
  import lphs_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_cmd_i,
  input  wire logic [31:0] in_key_i,
  input  wire logic        q_space_i,
  output logic             front_busy_o,
  output logic             job_valid_o,
  output lphs_job_t        job_o
);
  logic        s1_valid_q, s2_valid_q;
  logic        s1_cmd_q, s2_cmd_q;
  logic [31:0] s1_key_q, s2_key_q, s1_mix_q, s2_mix_q;
  logic [31:0] s1_mix_d, s2_mix_d, x1, x2;

  // The front holds one item at a time; it waits for queue space at the end.
  assign front_busy_o = s1_valid_q | s2_valid_q;
  assign job_valid_o  = s2_valid_q;

  always_comb begin
    x1       = in_key_i ^ (in_key_i >> 16);
    s1_mix_d = x1 * MixMulA;
    x2       = s1_mix_q ^ (s1_mix_q >> 13);
    s2_mix_d = x2 * MixMulB;
  end

  always_comb begin
    job_o.cmd  = s2_cmd_q;
    job_o.key  = s2_key_q;
    job_o.hash = s2_mix_q ^ (s2_mix_q >> 16);
  end

  // Control flags of the two stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (in_valid_i) s1_valid_q <= 1'b1;
      else if (s1_valid_q) s1_valid_q <= 1'b0;
      if (s1_valid_q) s2_valid_q <= 1'b1;
      else if (s2_valid_q && q_space_i) s2_valid_q <= 1'b0;
    end
  end

  // Payload of the two stages.
  always_ff @(posedge clk_i) begin
    if (in_valid_i) begin
      s1_cmd_q <= in_cmd_i;
      s1_key_q <= in_key_i;
      s1_mix_q <= s1_mix_d;
    end
    if (s1_valid_q) begin
      s2_cmd_q <= s1_cmd_q;
      s2_key_q <= s1_key_q;
      s2_mix_q <= s2_mix_d;
    end
  end
endmodule
`default_nettype wire

>>> rtl/lphs_queue.sv
// Short queue of hashed items between the front and back parts.
`default_nettype none
module lphs_queue
  import lphs_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  lphs_job_t      push_data_i,
  output logic           space_o,
  input  wire logic      pop_i,
  output logic           avail_o,
  output lphs_job_t      pop_data_o
);
  localparam int unsigned PtrW = $clog2(QueueDepth);
  lphs_job_t       store_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;

  assign space_o    = cnt_q != (PtrW+1)'(QueueDepth);
  assign avail_o    = cnt_q != '0;
  assign pop_data_o = store_q[rd_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PtrW'(QueueDepth-1)) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == PtrW'(QueueDepth-1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push_i) - (PtrW+1)'(pop_i);
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) store_q[wr_q] <= push_data_i;
  end
endmodule
`default_nettype wire

>>> rtl/lphs_back.sv
// Back part: clears the key memory after reset, then probes it, claims slots and reports results.
`default_nettype none
module lphs_back
  import lphs_pkg::*;
#(
  parameter int unsigned TableEntries = TableEntriesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        job_avail_i,
  input  lphs_job_t        job_i,
  output logic             job_pop_o,
  output logic             clearing_o,
  output logic             res_valid_o,
  output logic             res_found_o,
  output logic             res_inserted_o,
  output logic             res_table_full_o,
  output logic             res_zero_slot_o,
  output logic [9:0]       res_slot_index_o,
  output logic [10:0]      res_occupancy_o
);
  localparam int unsigned AddrW = $clog2(TableEntries);
  localparam int unsigned CntW  = AddrW + 1;
  localparam logic [CntW+1:0] LoadLim = (CntW+2)'(TableEntries * 3);

  typedef enum logic [4:0] {
    StClear = 5'b00001,
    StIdle  = 5'b00010,
    StRead  = 5'b00100,
    StCheck = 5'b01000,
    StDone  = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  logic [31:0]      mem [TableEntries];
  logic [31:0]      rd_data_q;
  logic [AddrW-1:0] pos_q, pos_d, pos_nx;
  logic [CntW-1:0]  steps_q, steps_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             zero_q, zero_d;
  logic             cmd_q;
  logic [31:0]      key_q;
  logic             wr_en;
  logic [31:0]      wr_data;
  logic             full_lim;
  logic             rv_d, rf_d, ri_d, rt_d, rz_d;
  logic [AddrW-1:0] rs_d;
  logic             rv_q, rf_q, ri_q, rt_q, rz_q;
  logic [AddrW-1:0] rs_q;

  assign full_lim   = ({2'b00, count_q} + 1'b1) * 4 >= LoadLim;
  assign pos_nx     = (pos_q == AddrW'(TableEntries-1)) ? '0 : pos_q + 1'b1;
  assign clearing_o = state_q == StClear;
  assign job_pop_o  = (state_q == StIdle) && job_avail_i;

  // Probe sequencer: clears the table after reset, then one read and one compare for each probed slot.
  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    steps_d = steps_q;
    count_d = count_q;
    zero_d  = zero_q;
    wr_en   = 1'b0;
    wr_data = key_q;
    rv_d = 1'b0; rf_d = 1'b0; ri_d = 1'b0; rt_d = 1'b0; rz_d = 1'b0; rs_d = '0;
    case (state_q)
      StClear: begin
        wr_en   = 1'b1;
        wr_data = '0;
        pos_d   = pos_nx;
        if (pos_q == AddrW'(TableEntries-1)) state_d = StIdle;
      end
      StIdle: begin
        if (job_avail_i) begin
          steps_d = '0;
          pos_d   = AddrW'(job_i.hash % TableEntries);
          if (job_i.key == '0) begin
            rv_d = 1'b1;
            if (zero_q) begin
              rf_d = 1'b1; rz_d = 1'b1;
            end else if (job_i.cmd == CmdInsert) begin
              if (full_lim) rt_d = 1'b1;
              else begin
                zero_d = 1'b1; count_d = count_q + 1'b1; ri_d = 1'b1; rz_d = 1'b1;
              end
            end
          end else begin
            state_d = StRead;
          end
        end
      end
      StRead: state_d = StCheck;
      StCheck: begin
        if (rd_data_q == key_q) begin
          rv_d = 1'b1; rf_d = 1'b1; rs_d = pos_q; state_d = StDone;
        end else if (rd_data_q == '0) begin
          rv_d = 1'b1; state_d = StDone;
          if (cmd_q == CmdInsert) begin
            if (full_lim) rt_d = 1'b1;
            else begin
              wr_en = 1'b1; count_d = count_q + 1'b1; ri_d = 1'b1; rs_d = pos_q;
            end
          end
        end else if (steps_q == CntW'(TableEntries-1)) begin
          rv_d = 1'b1; rt_d = cmd_q == CmdInsert; state_d = StDone;
        end else begin
          steps_d = steps_q + 1'b1; pos_d = pos_nx; state_d = StRead;
        end
      end
      StDone: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Key memory with a registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[pos_q] <= wr_data;
    rd_data_q <= mem[pos_q];
    if (job_pop_o) begin
      cmd_q <= job_i.cmd;
      key_q <= job_i.key;
    end
    rf_q <= rf_d; ri_q <= ri_d; rt_q <= rt_d; rz_q <= rz_d; rs_q <= rs_d;
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      pos_q   <= '0;
      steps_q <= '0;
      count_q <= '0;
      zero_q  <= 1'b0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      steps_q <= steps_d;
      count_q <= count_d;
      zero_q  <= zero_d;
      rv_q    <= rv_d;
    end
  end

  assign res_valid_o      = rv_q;
  assign res_found_o      = rf_q;
  assign res_inserted_o   = ri_q;
  assign res_table_full_o = rt_q;
  assign res_zero_slot_o  = rz_q;
  assign res_slot_index_o = 10'(rs_q);
  assign res_occupancy_o  = 11'(count_q);
endmodule
`default_nettype wire

>>> rtl/linear_probe_hash_set.sv
// Top level of the open-addressed 32-bit key set.
//
// Channel  Direction  Handshake              Fields
// command  in         start && !busy         command_i, key_i
// result   out        done_o (one cycle)     found_o .. occupancy_o
//
// An item passes the two hash stages and the queue; the back part then takes
// it from the queue, spends a memory read and a compare on each probed slot
// and reports the result in a done state. Key zero needs no probe: its result
// is formed as it is taken from the queue.
// After reset a clearing pass writes every slot with busy high. The receiver
// cannot stall; results are never held back.
`default_nettype none
module linear_probe_hash_set
  import lphs_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TableEntriesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        command_i,
  input  wire logic [31:0] key_i,
  output logic             done_o,
  output logic             found_o,
  output logic             inserted_o,
  output logic             table_full_o,
  output logic             zero_slot_o,
  output logic [9:0]       slot_index_o,
  output logic [10:0]      occupancy_o
);
  logic      front_busy, job_valid, q_space, q_avail, q_pop, clearing;
  lphs_job_t job, q_job;
  logic      accept;

  // The front takes an item only when it is empty.
  assign busy   = front_busy | clearing;
  assign accept = start & ~busy;

  lphs_front u_front (
    .clk_i, .rst_ni, .in_valid_i(accept), .in_cmd_i(command_i), .in_key_i(key_i),
    .q_space_i(q_space), .front_busy_o(front_busy), .job_valid_o(job_valid),
    .job_o(job)
  );

  lphs_queue u_queue (
    .clk_i, .rst_ni, .push_i(job_valid & q_space), .push_data_i(job),
    .space_o(q_space), .pop_i(q_pop), .avail_o(q_avail), .pop_data_o(q_job)
  );

  lphs_back #(.TableEntries(TABLE_ENTRIES)) u_back (
    .clk_i, .rst_ni, .job_avail_i(q_avail), .job_i(q_job), .job_pop_o(q_pop),
    .clearing_o(clearing), .res_valid_o(done_o),
    .res_found_o(found_o), .res_inserted_o(inserted_o),
    .res_table_full_o(table_full_o), .res_zero_slot_o(zero_slot_o),
    .res_slot_index_o(slot_index_o), .res_occupancy_o(occupancy_o)
  );
endmodule
`default_nettype wire

>>> rtl/lphs_checker.sv
// Port-level checks of the hash set, bound to the top level.
`default_nettype none
module lphs_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done_o,
  input wire logic        found_o,
  input wire logic        inserted_o,
  input wire logic        table_full_o,
  input wire logic        zero_slot_o,
  input wire logic [9:0]  slot_index_o,
  input wire logic [10:0] occupancy_o
);
  // A result carries at most one of found, inserted and refused.
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $onehot0({found_o, inserted_o, table_full_o}))
    else $error("conflicting result flags");
  // An insert leaves occupancy above zero.
  a_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && inserted_o) |-> occupancy_o != 11'd0)
    else $error("insert with empty occupancy");
  // On back-to-back results, one that does not insert leaves occupancy unchanged.
  a_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && $past(done_o) && !inserted_o |-> occupancy_o == $past(occupancy_o))
    else $error("occupancy moved without insert");
  // Misses and refusals report slot zero and no zero slot.
  a_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !found_o && !inserted_o) |-> (slot_index_o == 10'd0 && !zero_slot_o))
    else $error("miss with slot");
  // An accepted item makes the block busy next cycle.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised");
endmodule

bind linear_probe_hash_set lphs_checker u_lphs_checker (.*);
`default_nettype wire
